@@ design/idll_pkg.sv @@
// shared types, constants and helpers for the indexed doubly linked list unit
`default_nettype none

package idll_pkg;

  // table size and derived widths
  localparam int unsigned MAX_NODES = 64;
  localparam int unsigned ID_W      = 7;
  localparam int unsigned ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned VAL_W     = 32;

  // operation codes
  localparam logic [2:0] OP_PUSH_LEFT  = 3'd0;
  localparam logic [2:0] OP_PUSH_RIGHT = 3'd1;
  localparam logic [2:0] OP_DELETE     = 3'd2;
  localparam logic [2:0] OP_INS_BEFORE = 3'd3;
  localparam logic [2:0] OP_INS_AFTER  = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOTFOUND  = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // request payload
  typedef struct packed {
    logic [2:0]              operation;
    logic signed [VAL_W-1:0] value;
    logic [ID_W-1:0]         target_id;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [1:0]              status;
    logic [ID_W-1:0]         node_id;
    logic signed [VAL_W-1:0] element_value;
    logic [ID_W-1:0]         list_length;
    logic                    last;
  } out_item_t;

  // node memory access, one read and per-field writes at one address
  typedef struct packed {
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_value_en;
    logic                    wr_next_en;
    logic                    wr_prev_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_value;
    logic [ID_W-1:0]         wr_next;
    logic [ID_W-1:0]         wr_prev;
  } mem_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ID_W-1:0]         next;
    logic [ID_W-1:0]         prev;
  } mem_rsp_t;

  // node id (1 based) to table address
  function automatic logic [ADDR_W-1:0] id_to_addr(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - ID_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/idll_node_mem.sv @@
// node table memory: value, next and prev links with registered read
`default_nettype none

module idll_node_mem (
  input  wire                 clk,
  input  idll_pkg::mem_req_t  mem_req,
  output idll_pkg::mem_rsp_t  mem_rsp
);
  import idll_pkg::*;

  logic signed [VAL_W-1:0] value_mem [MAX_NODES];
  logic [ID_W-1:0]         next_mem  [MAX_NODES];
  logic [ID_W-1:0]         prev_mem  [MAX_NODES];
  mem_rsp_t                rsp_r;

  // per-field writes
  always_ff @(posedge clk) begin
    if (mem_req.wr_value_en) begin
      value_mem[mem_req.wr_addr] <= mem_req.wr_value;
    end
    if (mem_req.wr_next_en) begin
      next_mem[mem_req.wr_addr] <= mem_req.wr_next;
    end
    if (mem_req.wr_prev_en) begin
      prev_mem[mem_req.wr_addr] <= mem_req.wr_prev;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rsp_r.value <= value_mem[mem_req.rd_addr];
      rsp_r.next  <= next_mem[mem_req.rd_addr];
      rsp_r.prev  <= prev_mem[mem_req.rd_addr];
    end
  end

  assign mem_rsp = rsp_r;

endmodule

`default_nettype wire

@@ design/idll_ctrl.sv @@
// list control: decode, pointer read-modify-write sequencing and dump walk
`default_nettype none

module idll_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  idll_pkg::in_item_t   in_data,
  output logic                 res_valid,
  input  wire                  res_ready,
  output idll_pkg::out_item_t  res_data,
  output idll_pkg::mem_req_t   mem_req,
  input  idll_pkg::mem_rsp_t   mem_rsp
);
  import idll_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_WNEW  = 7'b0000100,
    S_WPRV  = 7'b0001000,
    S_WNXT  = 7'b0010000,
    S_DUMP  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [2:0]              op_r, op_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic [ID_W-1:0]         tid_r, tid_nxt;
  logic [ID_W-1:0]         new_id_r, new_id_nxt;
  logic [ID_W-1:0]         prv_r, prv_nxt;
  logic [ID_W-1:0]         nxt_r, nxt_nxt;
  logic [ID_W-1:0]         cur_r, cur_nxt;
  logic [ID_W-1:0]         k_r, k_nxt;
  logic [ID_W-1:0]         head_r, head_nxt;
  logic [ID_W-1:0]         tail_r, tail_nxt;
  logic [ID_W-1:0]         count_r, count_nxt;
  logic [ID_W-1:0]         issued_r, issued_nxt;
  logic [MAX_NODES-1:0]    live_r, live_nxt;
  logic [1:0]              res_status_r, res_status_nxt;
  logic [ID_W-1:0]         res_len_r, res_len_nxt;

  logic                    full;
  logic                    present;
  logic                    is_ins;
  logic [ID_W-1:0]         prv_link;
  logic [ID_W-1:0]         nxt_link;
  logic                    dump_last;

  // target lookup and allocation status
  assign full    = (issued_r >= ID_W'(MAX_NODES));
  assign present = (in_data.target_id != '0) &&
                   (in_data.target_id <= ID_W'(MAX_NODES)) &&
                   live_r[id_to_addr(in_data.target_id)];
  assign is_ins  = (op_r != OP_DELETE);

  // values written into the neighbors' links
  assign prv_link  = is_ins ? new_id_r : nxt_r;
  assign nxt_link  = is_ins ? new_id_r : prv_r;
  assign dump_last = ((k_r + ID_W'(1)) == count_r) || (mem_rsp.next == '0);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    tid_nxt        = tid_r;
    new_id_nxt     = new_id_r;
    prv_nxt        = prv_r;
    nxt_nxt        = nxt_r;
    cur_nxt        = cur_r;
    k_nxt          = k_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    issued_nxt     = issued_r;
    live_nxt       = live_r;
    res_status_nxt = res_status_r;
    res_len_nxt    = res_len_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    res_data       = '0;
    mem_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready        = 1'b1;
        mem_req.rd_addr = (in_data.operation == OP_DUMP) ? id_to_addr(head_r)
                                                         : id_to_addr(in_data.target_id);
        if (in_valid) begin
          mem_req.rd_en  = 1'b1;
          op_nxt         = in_data.operation;
          value_nxt      = in_data.value;
          tid_nxt        = in_data.target_id;
          new_id_nxt     = issued_r + ID_W'(1);
          cur_nxt        = head_r;
          k_nxt          = '0;
          res_status_nxt = ST_OK;
          res_len_nxt    = count_r;
          state_nxt      = S_RESP;
          unique case (in_data.operation)
            OP_PUSH_LEFT: begin
              if (full) begin
                res_status_nxt = ST_EXHAUSTED;
              end else begin
                prv_nxt   = '0;
                nxt_nxt   = head_r;
                state_nxt = S_WNEW;
              end
            end
            OP_PUSH_RIGHT: begin
              if (full) begin
                res_status_nxt = ST_EXHAUSTED;
              end else begin
                prv_nxt   = tail_r;
                nxt_nxt   = '0;
                state_nxt = S_WNEW;
              end
            end
            OP_DELETE: begin
              if (!present) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            OP_INS_BEFORE, OP_INS_AFTER: begin
              if (!present) begin
                res_status_nxt = ST_NOTFOUND;
              end else if (full) begin
                res_status_nxt = ST_EXHAUSTED;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            OP_DUMP: begin
              if ((count_r == '0) || (head_r == '0)) begin
                res_status_nxt = ST_EMPTY;
                res_len_nxt    = '0;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            default: begin
              // unused codes leave the list alone
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      // neighbor links of the target are now on the read port
      S_FETCH: begin
        if (op_r == OP_INS_BEFORE) begin
          prv_nxt = mem_rsp.prev;
          nxt_nxt = tid_r;
        end else if (op_r == OP_INS_AFTER) begin
          prv_nxt = tid_r;
          nxt_nxt = mem_rsp.next;
        end else begin
          prv_nxt = mem_rsp.prev;
          nxt_nxt = mem_rsp.next;
        end
        state_nxt = (op_r == OP_DELETE) ? S_WPRV : S_WNEW;
      end

      // new node entry
      S_WNEW: begin
        mem_req.wr_value_en = 1'b1;
        mem_req.wr_next_en  = 1'b1;
        mem_req.wr_prev_en  = 1'b1;
        mem_req.wr_addr     = id_to_addr(new_id_r);
        mem_req.wr_value    = value_r;
        mem_req.wr_next     = nxt_r;
        mem_req.wr_prev     = prv_r;
        state_nxt           = S_WPRV;
      end

      // left neighbor's next link, or the head
      S_WPRV: begin
        if (prv_r != '0) begin
          mem_req.wr_next_en = 1'b1;
          mem_req.wr_addr    = id_to_addr(prv_r);
          mem_req.wr_next    = prv_link;
        end else begin
          head_nxt = prv_link;
        end
        state_nxt = S_WNXT;
      end

      // right neighbor's prev link, or the tail, and the result
      S_WNXT: begin
        res_valid              = 1'b1;
        res_data.status        = ST_OK;
        res_data.node_id       = is_ins ? new_id_r : '0;
        res_data.element_value = '0;
        res_data.list_length   = is_ins ? (count_r + ID_W'(1)) : (count_r - ID_W'(1));
        res_data.last          = 1'b1;
        if (res_ready) begin
          if (nxt_r != '0) begin
            mem_req.wr_prev_en = 1'b1;
            mem_req.wr_addr    = id_to_addr(nxt_r);
            mem_req.wr_prev    = nxt_link;
          end else begin
            tail_nxt = nxt_link;
          end
          if (is_ins) begin
            count_nxt                      = count_r + ID_W'(1);
            issued_nxt                     = new_id_r;
            live_nxt[id_to_addr(new_id_r)] = 1'b1;
          end else begin
            count_nxt                   = count_r - ID_W'(1);
            live_nxt[id_to_addr(tid_r)] = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      // one element per cycle while res_ready, next read issued as the current one goes out
      S_DUMP: begin
        res_valid              = 1'b1;
        res_data.status        = ST_OK;
        res_data.node_id       = cur_r;
        res_data.element_value = mem_rsp.value;
        res_data.list_length   = count_r;
        res_data.last          = dump_last;
        mem_req.rd_addr        = id_to_addr(mem_rsp.next);
        if (res_ready) begin
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_req.rd_en = 1'b1;
            cur_nxt       = mem_rsp.next;
            k_nxt         = k_r + ID_W'(1);
          end
        end
      end

      // single result for rejected, empty or unused requests
      S_RESP: begin
        res_valid              = 1'b1;
        res_data.status        = res_status_r;
        res_data.node_id       = '0;
        res_data.element_value = '0;
        res_data.list_length   = res_len_r;
        res_data.last          = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      issued_r <= '0;
      live_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      issued_r <= issued_nxt;
      live_r   <= live_nxt;
    end
  end

  // request working registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    tid_r        <= tid_nxt;
    new_id_r     <= new_id_nxt;
    prv_r        <= prv_nxt;
    nxt_r        <= nxt_nxt;
    cur_r        <= cur_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_len_r    <= res_len_nxt;
  end

`ifndef SYNTHESIS
  // the list never holds more elements than ids handed out
  a_count_le_issued: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= issued_r)
    else $error("element count exceeds issued ids");

  // between requests an empty list has no head and no tail
  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((count_r == '0) == (head_r == '0)))
    else $error("head pointer disagrees with element count");

  a_tail_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((count_r == '0) == (tail_r == '0)))
    else $error("tail pointer disagrees with element count");

  // node table is only written by the link update steps
  a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_value_en || mem_req.wr_next_en || mem_req.wr_prev_en) |->
      ((state_r == S_WNEW) || (state_r == S_WPRV) || (state_r == S_WNXT)))
    else $error("node table written outside an update");

  // ids are never handed back
  a_issued_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (issued_r >= $past(issued_r)))
    else $error("issued id counter went backward");
`endif

endmodule

`default_nettype wire

@@ design/indexed_doubly_linked_list_unit.sv @@
// top level: node table, list control and result output register
`default_nettype none

// Doubly linked list of signed 32-bit values kept in a node table addressed
// by node id. Ids are handed out 1, 2, 3 and so on and are never reused;
// once all table entries have been issued every insert is refused with an
// exhausted status, or not found if its target is absent. Each request
// moves through the node memory, which has a single write port and a
// registered read, in steps set by the table entries it touches: push left
// or right writes the new entry, the left link and the right link; delete
// reads the target, then does two link writes; insert before or after
// reads the target, then does three writes; a dump emits one result per
// element with last on the final one; and a rejected, empty-dump or unused
// request gives a single result. A finished result waits in an output
// register, so the next request is taken while it is still pending
// downstream. No clearing pass is needed after reset.
module indexed_doubly_linked_list_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  idll_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output idll_pkg::out_item_t  out_data
);
  import idll_pkg::*;

  mem_req_t  mem_req;
  mem_rsp_t  mem_rsp;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;

  idll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  idll_node_mem u_node_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
